// File: hdl/vsa_pkg.sv
// vsa_pkg: shared types, codes and default sizes for the versioned slot allocator
// used by every module of the block but vsa_ram; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vsa_pkg;

  localparam int SLOT_COUNT_DEF   = 128;
  localparam int VERSION_BITS_DEF = 24;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_STALE   = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  slot_addr;
    logic [23:0] version;
  } op_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] granted_index;
  } res_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic exec_en;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic exec_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/versioned_slot_allocator_core.sv
// Versioned slot allocator, top level.
// Operations arrive on op_valid / op_stall / op_item; a transfer happens at a
// clock edge with op_valid high and op_stall low. Each operation yields one
// result on res_valid / res_stall / res_item, held in an output register.
// Alloc, free and check: the slot word is read from the store at the transfer;
// a successful alloc or free updates it once the output register is free, and
// the result is valid in the cycle after that. A new operation is not taken
// before the result is set; the slot store has a single registered read port.
// Flush: the transfer reads the deferred head, then the walk updates each chain
// entry in turn (at most SLOT_COUNT entries), reading the next link while it
// writes the current one, and waits while the output register is held.
// Reset (rst, synchronous): a clearing pass writes every slot in turn, rebuilds
// the free chain and zeroes every tag; op_stall stays high until it ends.
// A new operation is taken while a result still waits; if the receiver holds
// res_stall high, the next update waits until the output register is free.
// depends on vsa_pkg, vsa_ctrl, vsa_dpath
`timescale 1ns / 1ps
`default_nettype none

module versioned_slot_allocator_core #(
  parameter int SLOT_COUNT   = vsa_pkg::SLOT_COUNT_DEF,
  parameter int VERSION_BITS = vsa_pkg::VERSION_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              op_valid,
  output logic                   op_stall,
  input  wire vsa_pkg::op_item_t op_item,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output vsa_pkg::res_item_t     res_item
);
  import vsa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  vsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_stall (op_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vsa_dpath #(
    .SLOT_COUNT   (SLOT_COUNT),
    .VERSION_BITS (VERSION_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .op_item   (op_item),
    .cmd       (cmd),
    .stat      (stat),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

endmodule

`default_nettype wire

// File: hdl/vsa_ram.sv
// vsa_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module vsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/vsa_ctrl.sv
// vsa_ctrl: sequencing state machine of the slot allocator
// depends on vsa_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module vsa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                op_valid,
  output logic                     op_stall,
  input  wire vsa_pkg::dp_stat_t   stat,
  output vsa_pkg::ctrl_cmd_t       cmd
);
  import vsa_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (op_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // flush stays here while it walks the deferred chain
        cmd.exec_en = 1'b1;
        if (stat.exec_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign op_stall = (state != S_IDLE);

endmodule

`default_nettype wire

// File: hdl/vsa_dpath.sv
// vsa_dpath: slot store, chain heads, walk pointer and result register
// depends on vsa_pkg and vsa_ram
`timescale 1ns / 1ps
`default_nettype none

module vsa_dpath #(
  parameter int SLOT_COUNT   = vsa_pkg::SLOT_COUNT_DEF,
  parameter int VERSION_BITS = vsa_pkg::VERSION_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire vsa_pkg::op_item_t  op_item,
  input  wire vsa_pkg::ctrl_cmd_t cmd,
  output vsa_pkg::dp_stat_t       stat,
  input  wire logic               res_stall,
  output logic                    res_valid,
  output vsa_pkg::res_item_t      res_item
);
  import vsa_pkg::*;

  localparam int LW = $clog2(SLOT_COUNT + 1);   // one-based link width
  localparam int AW = $clog2(SLOT_COUNT);       // slot address width
  localparam int VB = VERSION_BITS;
  localparam int DW = 1 + VB + LW;              // {used, version, link}
  localparam int UB = DW - 1;
  localparam logic [LW-1:0] SC_L = LW'(SLOT_COUNT);

  logic [LW-1:0] free_head;
  logic [LW-1:0] deferred_head;
  logic [AW-1:0] clr_cnt;
  logic [1:0]    op_q;
  logic [VB-1:0] ver_q;
  logic          skip_q;
  logic [AW-1:0] cur_addr;
  logic [LW-1:0] steps;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] rd_data;

  logic [31:0]   ver_wide;
  logic [VB-1:0] ver_in;
  logic [16:0]   idx_wide;
  logic          in_pool;
  logic          fh_ok;
  logic          dh_ok;
  logic [LW-1:0] fh_m1;
  logic [LW-1:0] dh_m1;
  logic [AW-1:0] acc_addr;
  logic          acc_skip;

  logic [LW-1:0] clr_link;
  logic [DW-1:0] clr_word;

  logic [LW-1:0] w_link;
  logic [VB-1:0] w_ver;
  logic          w_used;
  logic [LW-1:0] w_link_m1;
  logic [AW-1:0] next_addr;
  logic [LW-1:0] steps_inc;
  logic [16:0]   cur_wide;
  logic          out_free;
  logic          go;
  logic          done;
  logic          ex_we;
  logic [DW-1:0] ex_wdata;
  logic          walk_rd;
  logic [1:0]    status;
  logic [6:0]    granted;
  logic [LW-1:0] fh_next;
  logic [LW-1:0] dh_next;

  vsa_ram #(
    .WIDTH (DW),
    .DEPTH (SLOT_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // input decode at the transfer
  assign ver_wide = 32'(op_item.version);
  assign ver_in   = ver_wide[VB-1:0];
  assign idx_wide = 17'(op_item.slot_addr);
  assign in_pool  = 32'(op_item.slot_addr) < 32'(SLOT_COUNT);
  assign fh_ok    = (free_head != '0) && (free_head <= SC_L);
  assign dh_ok    = (deferred_head != '0) && (deferred_head <= SC_L);
  assign fh_m1    = free_head - LW'(1);
  assign dh_m1    = deferred_head - LW'(1);

  always_comb begin
    case (op_item.opcode) inside
      OP_ALLOC: begin
        acc_addr = fh_m1[AW-1:0];
        acc_skip = !fh_ok;
      end
      OP_FREE, OP_CHECK: begin
        acc_addr = idx_wide[AW-1:0];
        acc_skip = !in_pool;
      end
      default: begin
        acc_addr = dh_m1[AW-1:0];
        acc_skip = !dh_ok;
      end
    endcase
  end

  // clearing pass rebuilds the full free chain
  assign stat.clear_last = (clr_cnt == AW'(SLOT_COUNT - 1));
  assign clr_link = stat.clear_last ? '0 : (LW'(clr_cnt) + LW'(2));
  assign clr_word = {1'b0, {VB{1'b0}}, clr_link};

  // execute step on the slot word read at the transfer or by the walk
  assign w_link    = rd_data[LW-1:0];
  assign w_ver     = rd_data[LW+VB-1:LW];
  assign w_used    = rd_data[UB];
  assign w_link_m1 = w_link - LW'(1);
  assign next_addr = w_link_m1[AW-1:0];
  assign steps_inc = steps + LW'(1);
  assign cur_wide  = 17'(cur_addr);
  assign out_free  = !res_valid || !res_stall;
  assign go        = cmd.exec_en && out_free;

  always_comb begin
    ex_we    = 1'b0;
    ex_wdata = rd_data;
    done     = 1'b0;
    walk_rd  = 1'b0;
    status   = ST_OK;
    granted  = '0;
    fh_next  = free_head;
    dh_next  = deferred_head;
    case (op_q)
      OP_ALLOC: begin
        done = 1'b1;
        if (skip_q) begin
          status = ST_FULL;
        end else begin
          ex_we    = 1'b1;
          ex_wdata = {1'b1, ver_q, w_link};
          fh_next  = w_link;
          granted  = cur_wide[6:0];
        end
      end
      OP_FREE: begin
        done = 1'b1;
        if (skip_q || !w_used || (w_ver != ver_q)) begin
          status = ST_IGNORED;
        end else begin
          ex_we    = 1'b1;
          ex_wdata = {1'b0, w_ver, deferred_head};
          dh_next  = LW'(cur_addr) + LW'(1);
        end
      end
      OP_CHECK: begin
        done = 1'b1;
        if (skip_q || (w_ver != ver_q)) begin
          status = ST_STALE;
        end
      end
      default: begin
        if (skip_q) begin
          done = 1'b1;
        end else begin
          ex_we = 1'b1;
          if (w_link == '0) begin
            // tail of the deferred chain: splice in front of the free chain
            ex_wdata = {w_used, {VB{1'b0}}, free_head};
            fh_next  = deferred_head;
            dh_next  = '0;
            done     = 1'b1;
          end else begin
            ex_wdata = {w_used, {VB{1'b0}}, w_link};
            if ((w_link <= SC_L) && (steps_inc < SC_L)) begin
              walk_rd = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
    endcase
  end

  assign stat.exec_done = go && done;

  always_comb begin
    ram_we    = cmd.clear_en || (go && ex_we);
    ram_waddr = cmd.clear_en ? clr_cnt : cur_addr;
    ram_wdata = cmd.clear_en ? clr_word : ex_wdata;
    ram_re    = cmd.accept || (go && walk_rd);
    ram_raddr = cmd.accept ? acc_addr : next_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head     <= LW'(1);
      deferred_head <= '0;
      clr_cnt       <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cmd.clear_en) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (go) begin
        free_head     <= fh_next;
        deferred_head <= dh_next;
      end
      if (go && done) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= op_item.opcode;
      ver_q    <= ver_in;
      skip_q   <= acc_skip;
      cur_addr <= acc_addr;
      steps    <= '0;
    end else if (go && walk_rd) begin
      cur_addr <= next_addr;
      steps    <= steps_inc;
    end
    if (go && done) begin
      res_item.status        <= status;
      res_item.granted_index <= granted;
    end
  end

endmodule

`default_nettype wire

// File: hdl/vsa_checker.sv
// vsa_checker: port-level assertions for the slot allocator, bound to the top level
// depends on vsa_pkg and versioned_slot_allocator_core
`timescale 1ns / 1ps
`default_nettype none

module vsa_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               op_valid,
  input wire logic               op_stall,
  input wire vsa_pkg::res_item_t res_item,
  input wire logic               res_valid,
  input wire logic               res_stall
);
  import vsa_pkg::*;

  // reset starts the clearing pass with no result pending
  a_reset_state: assert property (@(posedge clk)
    rst |=> (op_stall && !res_valid))
    else $error("op_stall low or result pending after reset");

  // a transfer is always followed by op_stall high while the operation executes
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !op_stall) |=> op_stall)
    else $error("operation taken in back-to-back cycles");

  // only a successful operation may carry a nonzero granted slot index
  a_grant_only_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_item.status != ST_OK)) |-> (res_item.granted_index == 7'd0))
    else $error("granted index set on a failed operation");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_item)))
    else $error("stalled result changed");

endmodule

bind versioned_slot_allocator_core vsa_checker u_vsa_checker (
  .clk       (clk),
  .rst       (rst),
  .op_valid  (op_valid),
  .op_stall  (op_stall),
  .res_item  (res_item),
  .res_valid (res_valid),
  .res_stall (res_stall)
);

`default_nettype wire
